// File: hw/rtl/shc_pkg.sv
package shc_pkg;

  localparam int unsigned MAX_CLUSTERS = 1024;
  localparam int unsigned HASH_SLOTS   = 2048;
  localparam int unsigned CLUSTER_W    = 10;
  localparam int unsigned SLOT_W       = 11;
  localparam int unsigned COUNT_W      = 11;

  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam logic [31:0] HASH_MUL_Z = 32'd83492791;
  localparam logic [31:0] INV_CELL_RESET = 32'd65536;

  typedef struct packed {
    logic               restart;
    logic               first_point;
    logic [23:0]        curve_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [23:0]          curve_out;
    logic [CLUSTER_W-1:0] cluster_id;
    logic                 new_cluster;
    logic                 table_full;
    logic signed [31:0]   box_min_x;
    logic signed [31:0]   box_min_y;
    logic signed [31:0]   box_min_z;
    logic signed [31:0]   box_max_x;
    logic signed [31:0]   box_max_y;
    logic signed [31:0]   box_max_z;
  } out_t;

  // classified point handed from front to back
  typedef struct packed {
    logic              restart;
    logic              first_point;
    logic [23:0]       curve_id;
    logic [2:0][31:0]  pos;
    logic [2:0][31:0]  key;
    logic [SLOT_W-1:0] hash;
  } job_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0][31:0]     key;
    logic [CLUSTER_W-1:0] cluster;
  } slot_t;

  typedef struct packed {
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

  // home slot: only the low bits of each product reach the index
  function automatic logic [SLOT_W-1:0] hash_idx(input logic [2:0][31:0] k);
    logic [2*SLOT_W-1:0] hx, hy, hz;
    hx = k[0][SLOT_W-1:0] * HASH_MUL_X[SLOT_W-1:0];
    hy = k[1][SLOT_W-1:0] * HASH_MUL_Y[SLOT_W-1:0];
    hz = k[2][SLOT_W-1:0] * HASH_MUL_Z[SLOT_W-1:0];
    return hx[SLOT_W-1:0] ^ hy[SLOT_W-1:0] ^ hz[SLOT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/shc_ram.sv
module shc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/shc_front.sv
module shc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  shc_pkg::in_t  in_data,
  input  logic [31:0]   inv_cell,
  output logic          push,
  output shc_pkg::job_t push_data,
  input  logic          q_full
);
  import shc_pkg::*;

  logic                    v_r;
  in_t                     it_r;
  logic signed [64:0]      prod_r [3];
  logic signed [64:0]      prod_nxt [3];
  logic [2:0][31:0]        key;
  logic                    take;

  assign busy = v_r & q_full;
  assign take = start & ~busy;
  assign push = v_r & ~q_full;

  // grid cell per axis: floor of the Q16.16 product is its high word
  always_comb begin
    prod_nxt[0] = $signed(in_data.pos_x) * $signed({1'b0, inv_cell});
    prod_nxt[1] = $signed(in_data.pos_y) * $signed({1'b0, inv_cell});
    prod_nxt[2] = $signed(in_data.pos_z) * $signed({1'b0, inv_cell});
    for (int a = 0; a < 3; a++) begin
      key[a] = prod_r[a][63:32];
    end
  end

  always_comb begin
    push_data.restart     = it_r.restart;
    push_data.first_point = it_r.first_point;
    push_data.curve_id    = it_r.curve_id;
    push_data.pos         = {it_r.pos_z, it_r.pos_y, it_r.pos_x};
    push_data.key         = key;
    push_data.hash        = hash_idx(key);
  end

  // hold the product stage until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= 1'b1;
    end else if (push) begin
      v_r <= 1'b0;
    end
    if (take) begin
      it_r <= in_data;
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= prod_nxt[a];
      end
    end
  end

endmodule

// File: hw/rtl/shc_queue.sv
module shc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  shc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output shc_pkg::job_t pop_data
);
  import shc_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/shc_back.sv
module shc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  shc_pkg::job_t  q_data,
  output logic           pop,
  output logic           out_strobe,
  output shc_pkg::out_t  out_data
);
  import shc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_PROBE_RD, S_PROBE_CHK, S_BOX_RD, S_BOX_UPD
  } state_t;

  state_t               state_r;
  job_t                 it_r;
  logic                 pend_r;
  logic [SLOT_W-1:0]    clr_r, idx_r, n_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic [CLUSTER_W-1:0] cur_r;
  logic                 live_r;
  logic                 new_r;
  logic                 out_v_r;
  out_t                 out_r;
  out_t                 drop_out;

  logic                 s_we;
  logic [SLOT_W-1:0]    s_waddr, s_raddr;
  slot_t                s_wdata, s_rdata;
  logic                 b_we;
  box_t                 b_wdata, b_rdata, b_upd, b_fresh;

  shc_ram #(.WIDTH($bits(slot_t)), .DEPTH(HASH_SLOTS)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  shc_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_CLUSTERS)) u_box (
    .clk(clk), .we(b_we), .waddr(cur_r), .wdata(b_wdata),
    .raddr(cur_r), .rdata(b_rdata)
  );

  assign pop        = (state_r == S_IDLE) & ~q_empty;
  assign s_raddr    = idx_r;
  assign out_strobe = out_v_r;
  assign out_data   = out_r;

  // dropped point: echo the curve, flag it, zero the rest
  always_comb begin
    drop_out = '{curve_out: it_r.curve_id, table_full: 1'b1, default: '0};
  end

  // widen the stored box by the point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      b_upd.lo[a] = ($signed(it_r.pos[a]) < $signed(b_rdata.lo[a])) ?
                    it_r.pos[a] : b_rdata.lo[a];
      b_upd.hi[a] = ($signed(it_r.pos[a]) > $signed(b_rdata.hi[a])) ?
                    it_r.pos[a] : b_rdata.hi[a];
    end
  end

  // a fresh cluster: the empty box widened by its root point
  always_comb begin
    b_fresh.lo = it_r.pos;
    b_fresh.hi = it_r.pos;
  end

  // slot and box writes: clearing pass, a new cell claim or the box update
  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx_r;
    s_wdata = '0;
    b_we    = 1'b0;
    b_wdata = new_r ? b_fresh : b_upd;
    case (state_r)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
      end
      S_PROBE_CHK: begin
        if (!s_rdata.valid && cnt_r < COUNT_W'(MAX_CLUSTERS)) begin
          s_we          = 1'b1;
          s_wdata.valid = 1'b1;
          s_wdata.key   = it_r.key;
          s_wdata.cluster = cnt_r[CLUSTER_W-1:0];
        end
      end
      S_BOX_UPD: b_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      cur_r   <= '0;
      live_r  <= 1'b0;
      new_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          out_v_r <= 1'b0;
          clr_r   <= clr_r + 1'b1;
          if (clr_r == SLOT_W'(HASH_SLOTS - 1)) begin
            state_r <= pend_r ? S_DISPATCH : S_IDLE;
          end
        end
        S_IDLE: begin
          out_v_r <= 1'b0;
          if (!q_empty) begin
            it_r <= q_data;
            if (q_data.restart) begin
              cnt_r   <= '0;
              cur_r   <= '0;
              live_r  <= 1'b0;
              pend_r  <= 1'b1;
              clr_r   <= '0;
              state_r <= S_CLEAR;
            end else begin
              state_r <= S_DISPATCH;
            end
          end
        end
        S_DISPATCH: begin
          pend_r <= 1'b0;
          new_r  <= 1'b0;
          if (it_r.first_point) begin
            out_v_r <= 1'b0;
            live_r  <= 1'b0;
            idx_r   <= it_r.hash;
            n_r     <= '0;
            state_r <= S_PROBE_RD;
          end else if (live_r) begin
            out_v_r <= 1'b0;
            state_r <= S_BOX_RD;
          end else begin
            out_v_r <= 1'b1;
            out_r   <= drop_out;
            state_r <= S_IDLE;
          end
        end
        S_PROBE_RD: begin
          out_v_r <= 1'b0;
          state_r <= S_PROBE_CHK;
        end
        S_PROBE_CHK: begin
          if (!s_rdata.valid && cnt_r < COUNT_W'(MAX_CLUSTERS)) begin
            // free slot: claim a new cluster
            out_v_r <= 1'b0;
            cur_r   <= cnt_r[CLUSTER_W-1:0];
            cnt_r   <= cnt_r + 1'b1;
            live_r  <= 1'b1;
            new_r   <= 1'b1;
            state_r <= S_BOX_UPD;
          end else if (!s_rdata.valid) begin
            // free slot but clusters exhausted: drop
            out_v_r <= 1'b1;
            out_r   <= drop_out;
            state_r <= S_IDLE;
          end else if (s_rdata.key == it_r.key) begin
            out_v_r <= 1'b0;
            cur_r   <= s_rdata.cluster;
            live_r  <= 1'b1;
            state_r <= S_BOX_RD;
          end else if (n_r == SLOT_W'(HASH_SLOTS - 1)) begin
            out_v_r <= 1'b1;
            out_r   <= drop_out;
            state_r <= S_IDLE;
          end else begin
            out_v_r <= 1'b0;
            idx_r   <= idx_r + 1'b1;
            n_r     <= n_r + 1'b1;
            state_r <= S_PROBE_RD;
          end
        end
        S_BOX_RD: begin
          out_v_r <= 1'b0;
          state_r <= S_BOX_UPD;
        end
        S_BOX_UPD: begin
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
          out_r   <= '{curve_out: it_r.curve_id, cluster_id: cur_r, new_cluster: new_r,
                       table_full: 1'b0,
                       box_min_x: b_wdata.lo[0], box_min_y: b_wdata.lo[1],
                       box_min_z: b_wdata.lo[2], box_max_x: b_wdata.hi[0],
                       box_max_y: b_wdata.hi[1], box_max_z: b_wdata.hi[2]};
        end
        default: begin
          out_v_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/spatial_hash_cluster_binning_unit.sv
// Channel   Ports                           Handshake
// input     start, busy, in_data            transfer when start & ~busy
// result    out_strobe, out_data            one-cycle strobe, no back-pressure
// config    cfg_we, cfg_wdata               write when cfg_we
//
// The back end takes one point at a time: a stray point is dropped at dispatch, a
// non-root point reads then updates its box, and a root probes the key table slot by
// slot from its home slot, then opens a cluster or reads the box it hits before the
// update. The front end registers the cell products at transfer and queues the point
// once the queue has room. After reset, and for every point with restart set, a
// clearing pass sweeps all 2048 key-table slots; busy is high while the two-entry
// queue is full and the front stage holds a point. Results cannot be stalled.
module spatial_hash_cluster_binning_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  shc_pkg::in_t   in_data,
  output logic           out_strobe,
  output shc_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import shc_pkg::*;

  logic [31:0] inv_cell_r;
  logic        push, q_full, q_empty, pop;
  job_t        push_data, pop_data;

  // hold the cell-size reciprocal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_cell_r <= INV_CELL_RESET;
    end else if (cfg_we) begin
      inv_cell_r <= cfg_wdata;
    end
  end

  shc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .inv_cell(inv_cell_r), .push(push), .push_data(push_data), .q_full(q_full)
  );

  shc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .empty(q_empty), .pop_data(pop_data)
  );

  shc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(pop_data), .pop(pop),
    .out_strobe(out_strobe), .out_data(out_data)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import shc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_strobe;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  spatial_hash_cluster_binning_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] scale_q;
  logic        slot_used[HASH_SLOTS];
  logic [31:0] slot_cell[HASH_SLOTS][3];
  logic [9:0]  slot_clu[HASH_SLOTS];
  logic signed [31:0] box_lo[MAX_CLUSTERS][3];
  logic signed [31:0] box_hi[MAX_CLUSTERS][3];
  int unsigned clusters_made;
  logic [9:0]  live_cluster;
  logic        curve_live;

  in_t  pending_points[$];
  out_t expected_bins[$];
  int   mismatches = 0;
  int   points_sent = 0;
  int   bins_seen = 0;
  int   drops_seen = 0;
  int   new_seen = 0;

  function automatic logic [31:0] grid_cell(logic signed [31:0] coord);
    logic signed [63:0] c64;
    logic signed [63:0] s64;
    logic signed [63:0] prod;
    c64 = 64'(coord);
    s64 = {32'd0, scale_q};
    prod = c64 * s64;
    return prod[63:32];
  endfunction

  function automatic void clear_bins();
    for (int i = 0; i < HASH_SLOTS; i++) slot_used[i] = 1'b0;
    clusters_made = 0;
    live_cluster = '0;
    curve_live = 1'b0;
  endfunction

  function automatic out_t bin_point(in_t p);
    out_t r;
    logic [31:0] gkey[3];
    logic signed [31:0] pos[3];
    logic [63:0] h;
    logic [SLOT_W-1:0] idx;
    logic created;
    r = '0;
    created = 1'b0;
    pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
    if (p.restart) clear_bins();
    if (p.first_point) begin
      curve_live = 1'b0;
      for (int a = 0; a < 3; a++) gkey[a] = grid_cell(pos[a]);
      h = ({32'd0, gkey[0]} * 64'd73856093) ^ ({32'd0, gkey[1]} * 64'd19349663) ^
          ({32'd0, gkey[2]} * 64'd83492791);
      idx = h[SLOT_W-1:0];
      for (int n = 0; n < HASH_SLOTS; n++) begin
        if (!slot_used[idx]) begin
          if (clusters_made < MAX_CLUSTERS) begin
            slot_used[idx] = 1'b1;
            for (int a = 0; a < 3; a++) begin
              slot_cell[idx][a] = gkey[a];
              box_lo[clusters_made][a] = 32'h7FFFFFFF;
              box_hi[clusters_made][a] = 32'h80000000;
            end
            slot_clu[idx] = clusters_made[9:0];
            live_cluster = clusters_made[9:0];
            clusters_made++;
            curve_live = 1'b1;
            created = 1'b1;
          end
          break;
        end
        if (slot_cell[idx][0] == gkey[0] && slot_cell[idx][1] == gkey[1] &&
            slot_cell[idx][2] == gkey[2]) begin
          live_cluster = slot_clu[idx];
          curve_live = 1'b1;
          break;
        end
        idx = idx + 1'b1;
      end
    end
    r.curve_out = p.curve_id;
    if (!curve_live) begin
      r.table_full = 1'b1;
      return r;
    end
    // widen the box of the live cluster
    for (int a = 0; a < 3; a++) begin
      if (pos[a] < box_lo[live_cluster][a]) box_lo[live_cluster][a] = pos[a];
      if (pos[a] > box_hi[live_cluster][a]) box_hi[live_cluster][a] = pos[a];
    end
    r.cluster_id = live_cluster;
    r.new_cluster = created;
    r.box_min_x = box_lo[live_cluster][0];
    r.box_min_y = box_lo[live_cluster][1];
    r.box_min_z = box_lo[live_cluster][2];
    r.box_max_x = box_hi[live_cluster][0];
    r.box_max_y = box_hi[live_cluster][1];
    r.box_max_z = box_hi[live_cluster][2];
    return r;
  endfunction

  // append a point to the pending list
  function automatic void queue_point(in_t p);
    pending_points = {pending_points, p};
  endfunction

  // driver: hold a point until transfer, then idle a random gap
  int gap_left = 0;
  always @(posedge clk) begin
    logic next_start;
    in_t next_data;
    if (rst_n) begin
      next_start = start;
      next_data = in_data;
      if (start && !busy) begin
        expected_bins = {expected_bins, bin_point(in_data)};
        points_sent++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_points.size() > 0) begin
          next_data = pending_points.pop_front();
          next_start = 1'b1;
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
      end
      start <= next_start;
      in_data <= next_data;
    end
  end

  // monitor: match each strobe against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      bins_seen++;
      if (out_data.table_full) drops_seen++;
      if (out_data.new_cluster) new_seen++;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = expected_bins.pop_front();
        if (out_data.curve_out !== want.curve_out || out_data.cluster_id !== want.cluster_id ||
            out_data.new_cluster !== want.new_cluster ||
            out_data.table_full !== want.table_full ||
            out_data.box_min_x !== want.box_min_x || out_data.box_min_y !== want.box_min_y ||
            out_data.box_min_z !== want.box_min_z || out_data.box_max_x !== want.box_max_x ||
            out_data.box_max_y !== want.box_max_y || out_data.box_max_z !== want.box_max_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_t make_point(logic rs, logic fp, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z);
    in_t p;
    p.restart = rs;
    p.first_point = fp;
    p.curve_id = 24'($urandom());
    p.pos_x = x; p.pos_y = y; p.pos_z = z;
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return ((32'($urandom_range(0, 4)) - 32'd2) << 16) + 32'($urandom_range(0, 65535));
  endfunction

  // wait until everything sent has come back; sample after the edge settles
  task automatic drain();
    while (pending_points.size() > 0 || start || expected_bins.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_scale(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_q = v;
  endtask

  // random curves: mostly well formed, some strays and restarts
  task automatic random_curves(int count);
    int n;
    n = 0;
    while (n < count) begin
      int len;
      len = $urandom_range(1, 6);
      queue_point(make_point($urandom_range(0, 199) == 0,
        $urandom_range(0, 19) != 0, rand_coord(), rand_coord(), rand_coord()));
      for (int k = 1; k < len; k++)
        queue_point(make_point(1'b0, 1'b0, $urandom(), $urandom(), $urandom()));
      n += len;
    end
  endtask

  logic [31:0] scales[5] = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd65536, 32'd20000};

  initial begin
    scale_q = INV_CELL_RESET;
    clear_bins();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray after reset, extremes, hits, strays after restart
    queue_point(make_point(1'b0, 1'b0, 32'd5, 32'd5, 32'd5));
    queue_point(make_point(1'b0, 1'b1, 32'h7FFFFFFF, 32'h80000000, 32'd0));
    queue_point(make_point(1'b0, 1'b0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
    queue_point(make_point(1'b0, 1'b1, 32'h7FFF0000, 32'h80000000, 32'd1));
    queue_point(make_point(1'b0, 1'b1, 32'h00010000, 32'h0, 32'h0));
    queue_point(make_point(1'b0, 1'b1, 32'h0001FFFF, 32'h0, 32'h0000FFFF));
    queue_point(make_point(1'b0, 1'b0, 32'hFFFFFFFF, 32'h0, 32'h0));
    queue_point(make_point(1'b1, 1'b0, 32'd1, 32'd2, 32'd3));
    queue_point(make_point(1'b0, 1'b0, 32'd1, 32'd2, 32'd3));
    queue_point(make_point(1'b1, 1'b1, 32'hFFFF0000, 32'hFFFFFFFF, 32'h0));
    queue_point(make_point(1'b0, 1'b1, 32'hFFFF8000, 32'hFFFF0001, 32'h8000));
    drain();

    // several scale settings, each starting from a cleared table
    foreach (scales[i]) begin
      set_scale(scales[i]);
      queue_point(make_point(1'b1, 1'b1, rand_coord(), rand_coord(), rand_coord()));
      random_curves(120);
      drain();
    end

    // exhaust the clusters with distinct cells, then hit and miss
    set_scale(32'd65536);
    queue_point(make_point(1'b1, 1'b1, 32'h0, 32'h0, 32'h0));
    for (int i = 1; i < MAX_CLUSTERS + 8; i++)
      queue_point(make_point(1'b0, 1'b1, i << 16, 32'h0, 32'h0));
    for (int i = 0; i < 40; i++)
      queue_point(make_point(1'b0, 1'($urandom_range(0, 1)),
        $urandom_range(0, 1100) << 16, 32'h0, 32'h0));
    drain();

    $display("Run covered %0d points over %0d scale settings: %0d results, %0d new clusters,",
             points_sent, 6, bins_seen, new_seen);
    $display("%0d dropped points, %0d mismatches", drops_seen, mismatches);
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/shc_pkg.sv
hw/rtl/shc_ram.sv
hw/rtl/shc_front.sv
hw/rtl/shc_queue.sv
hw/rtl/shc_back.sv
hw/rtl/spatial_hash_cluster_binning_unit.sv
tb/tb.sv
